// ===== hdl/msp_pkg.sv =====
// Shared types, constants and the angle-to-length function for the servo pulse generator.
`timescale 1ns / 1ps
package msp_pkg;

  localparam int Channels    = 8;
  localparam int ChanIdxW    = 3;
  localparam int AngleW      = 8;
  localparam int LenW        = 5;
  localparam int PeriodW     = 8;
  localparam int ActiveW     = 4;
  localparam int LevelsW     = 8;
  localparam int CntW        = ($clog2(Channels + 1) > ActiveW) ?
                               $clog2(Channels + 1) : ActiveW;
  localparam int PinPadW     = (Channels > LevelsW) ? Channels : LevelsW;
  localparam int ScaledW     = AngleW + 3;

  localparam logic [AngleW-1:0]  AngleMax    = 8'd180;
  localparam int                 LenSpan     = 8;
  localparam logic [LenW-1:0]    LenBase     = 5'd8;
  localparam logic [LenW-1:0]    LenReset    = 5'd10;
  localparam logic [PeriodW-1:0] PeriodReset = 8'd156;

  localparam logic CmdTick = 1'b0;
  localparam logic CmdSet  = 1'b1;

  localparam logic RegActive = 1'b0;
  localparam logic RegPeriod = 1'b1;

  typedef struct packed {
    logic                command;
    logic [ChanIdxW-1:0] channel;
    logic [AngleW-1:0]   angle;
  } item_t;

  typedef struct packed {
    logic [CntW-1:0]    eff_count;
    logic [PeriodW-1:0] period;
  } cfg_t;

  // 8 + min(angle,180)*8/180, done as eight threshold compares
  function automatic logic [LenW-1:0] pulse_len(input logic [AngleW-1:0] angle);
    logic [AngleW-1:0]  clamped;
    logic [ScaledW-1:0] scaled;
    logic [LenW-1:0]    steps;
    clamped = (angle > AngleMax) ? AngleMax : angle;
    scaled  = {clamped, 3'b000};
    steps   = '0;
    for (int k = 1; k <= LenSpan; k++) begin
      if (scaled >= ScaledW'(int'(AngleMax) * k)) begin
        steps = steps + LenW'(1);
      end
    end
    return LenBase + steps;
  endfunction

endpackage

// ===== hdl/multi_channel_servo_pwm.sv =====
// Top level of the multi-channel servo pulse generator.
`timescale 1ns / 1ps
// Usage:
//   Slave stream carries commands: tuser = command (0 tick, 1 set angle),
//   tdata = channel and angle. Each beat yields exactly one master beat with
//   the channel output levels and a request-accepted flag.
//   Config channel (cfg_valid_i/cfg_ready_o, always ready) writes register 0
//   (active channel count) and register 1 (frame length in ticks); write it
//   only while no beat is in flight.
//   Path: a command beat is taken into the input register, then the channel
//   update writes the result register, which drives m_axis_tvalid_o.
//   Throughput: one beat per cycle while m_axis_tready_i keeps up, with the
//   channel update combinational between the two registers.
//   Reset: no channels active, frame length 156, every stored pulse length
//   10 ticks, all channel pins low, no result pending.
//   Stall: while m_axis_tready_i is low the result holds; one more command is
//   taken into the input register, then s_axis_tready_o drops until the
//   result is taken.
module multi_channel_servo_pwm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [2:0] channel, [10:3] angle, zero pad
  input  logic        s_axis_tuser_i,   // [0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] output_levels, [8] request_accepted
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [msp_pkg::ActiveW-1:0] active_q;
  logic [msp_pkg::PeriodW-1:0] period_q;
  msp_pkg::cfg_t               cfg;
  msp_pkg::item_t              in_item, item;
  logic                        item_valid, pop;
  logic [msp_pkg::LevelsW-1:0] levels;
  logic                        accepted;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      period_q <= msp_pkg::PeriodReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        msp_pkg::RegActive: active_q <= cfg_data_i[msp_pkg::ActiveW-1:0];
        msp_pkg::RegPeriod: period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp the active count to the channels built
  always_comb begin
    cfg.period = period_q;
    if (msp_pkg::CntW'(active_q) > msp_pkg::CntW'(msp_pkg::Channels)) begin
      cfg.eff_count = msp_pkg::CntW'(msp_pkg::Channels);
    end else begin
      cfg.eff_count = msp_pkg::CntW'(active_q);
    end
  end

  assign in_item.command = s_axis_tuser_i;
  assign in_item.channel = s_axis_tdata_i[2:0];
  assign in_item.angle   = s_axis_tdata_i[10:3];

  msp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop)
  );

  msp_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .levels_o     (levels),
    .accepted_o   (accepted)
  );

  assign m_axis_tdata_o = {7'b0, accepted, levels};

endmodule

// ===== hdl/msp_in_reg.sv =====
// Input register stage: captures one command beat and holds it until the engine pops it.
`timescale 1ns / 1ps
module msp_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  msp_pkg::item_t  in_item_i,
  output logic            item_valid_o,
  output msp_pkg::item_t  item_o,
  input  logic            pop_i
);

  logic           valid_q, valid_d;
  msp_pkg::item_t item_q;

  assign in_ready_o   = !valid_q || pop_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ===== hdl/msp_engine.sv =====
// Channel state, combinational item update and the result register.
`timescale 1ns / 1ps
module msp_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  msp_pkg::cfg_t                cfg_i,
  input  logic                         item_valid_i,
  input  msp_pkg::item_t               item_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [msp_pkg::LevelsW-1:0]  levels_o,
  output logic                         accepted_o
);

  logic [msp_pkg::LenW-1:0]     len_q [msp_pkg::Channels];
  logic [msp_pkg::LenW-1:0]     len_d [msp_pkg::Channels];
  logic [msp_pkg::LenW-1:0]     rem_q [msp_pkg::Channels];
  logic [msp_pkg::LenW-1:0]     rem_d [msp_pkg::Channels];
  logic [msp_pkg::Channels-1:0] pin_q, pin_d;
  logic [msp_pkg::PeriodW-1:0]  frame_q, frame_d, frame_dec;
  logic                         wrap;
  logic [msp_pkg::LenW-1:0]     new_len;
  logic                         chan_ok;
  logic                         out_valid_q, out_valid_d;
  logic [msp_pkg::LevelsW-1:0]  levels_q;
  logic                         accepted_q;
  logic [msp_pkg::PinPadW-1:0]  pin_pad;
  logic [msp_pkg::Channels-1:0] rem_nz;
  logic [msp_pkg::Channels-1:0] len_ok;

  assign pop_o       = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign levels_o    = levels_q;
  assign accepted_o  = accepted_q;

  assign new_len   = msp_pkg::pulse_len(item_i.angle);
  assign chan_ok   = msp_pkg::CntW'(item_i.channel) < cfg_i.eff_count;
  assign frame_dec = frame_q - msp_pkg::PeriodW'(1);
  assign wrap      = (frame_dec == '0);
  assign pin_pad   = msp_pkg::PinPadW'(pin_d);

  always_comb begin
    frame_d = frame_q;
    pin_d   = pin_q;
    for (int i = 0; i < msp_pkg::Channels; i++) begin
      len_d[i] = len_q[i];
      rem_d[i] = rem_q[i];
      if (item_i.command == msp_pkg::CmdSet) begin
        if (chan_ok && msp_pkg::CntW'(item_i.channel) == msp_pkg::CntW'(i)) begin
          len_d[i] = new_len;
        end
      end else if (msp_pkg::CntW'(i) < cfg_i.eff_count) begin
        // count down a running pulse, drop the pin as it expires
        if (rem_q[i] != '0) begin
          rem_d[i] = rem_q[i] - msp_pkg::LenW'(1);
          if (rem_q[i] == msp_pkg::LenW'(1)) begin
            pin_d[i] = 1'b0;
          end
        end
        if (wrap) begin
          rem_d[i] = len_q[i];
          pin_d[i] = 1'b1;
        end
      end
    end
    if (item_i.command == msp_pkg::CmdTick) begin
      frame_d = wrap ? cfg_i.period : frame_dec;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < msp_pkg::Channels; i++) begin
        len_q[i] <= msp_pkg::LenReset;
        rem_q[i] <= '0;
      end
      pin_q       <= '0;
      frame_q     <= msp_pkg::PeriodReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        for (int i = 0; i < msp_pkg::Channels; i++) begin
          len_q[i] <= len_d[i];
          rem_q[i] <= rem_d[i];
        end
        pin_q   <= pin_d;
        frame_q <= frame_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      levels_q   <= pin_pad[msp_pkg::LevelsW-1:0];
      accepted_q <= (item_i.command == msp_pkg::CmdSet) && chan_ok;
    end
  end

  always_comb begin
    for (int i = 0; i < msp_pkg::Channels; i++) begin
      rem_nz[i] = (rem_q[i] != '0);
      len_ok[i] = (len_q[i] >= msp_pkg::LenBase) &&
                  (len_q[i] <= msp_pkg::LenBase + msp_pkg::LenW'(msp_pkg::LenSpan));
    end
  end

`ifndef ASSERT_OFF
  // a running pulse always has its pin high
  a_rem_implies_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_nz & ~pin_q) == '0)
    else $error("pulse counter running with pin low");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &len_ok)
    else $error("stored pulse length out of range");

  a_tick_not_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.command == msp_pkg::CmdTick |=> !accepted_q)
    else $error("tick reported as accepted request");

  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped item produced no result");
`endif

endmodule
